### sv/pa_pkg.sv
// shared types and constants for the primitive assembler
package pa_pkg;
   localparam int SLOTS = 8;
   localparam int SLOT_W = 3;
   localparam int ATTR_W = 192;

   typedef enum logic [1:0] {
      OP_BEGIN  = 2'd0,
      OP_VERTEX = 2'd1,
      OP_SUBMIT = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   localparam logic [3:0] MODE_POINTS    = 4'd0;
   localparam logic [3:0] MODE_LINES     = 4'd1;
   localparam logic [3:0] MODE_LOOP      = 4'd2;
   localparam logic [3:0] MODE_STRIP     = 4'd3;
   localparam logic [3:0] MODE_TRIS      = 4'd4;
   localparam logic [3:0] MODE_TRISTRIP  = 4'd5;
   localparam logic [3:0] MODE_FAN       = 4'd6;
   localparam logic [3:0] MODE_QUADSTRIP = 4'd7;
   localparam logic [3:0] MODE_QUADS     = 4'd8;
   localparam logic [3:0] MODE_POLYGON   = 4'd9;

   localparam logic [1:0] KIND_POINT = 2'd0;
   localparam logic [1:0] KIND_LINE  = 2'd1;
   localparam logic [1:0] KIND_FACET = 2'd2;

   localparam logic [1:0] CSR_FRONT_CW     = 2'd0;
   localparam logic [1:0] CSR_RENDER_FRONT = 2'd1;
   localparam logic [1:0] CSR_RENDER_BACK  = 2'd2;

   typedef struct packed {
      logic [1:0] opcode;
      logic [3:0] draw_mode;
      logic [31:0] vertex_x;
      logic [31:0] vertex_y;
      logic [31:0] vertex_depth;
      logic [31:0] vertex_color;
      logic [31:0] tex_u;
      logic [31:0] tex_v;
   } req_type;

   typedef struct packed {
      logic [1:0] prim_kind;
      logic [1:0] cull_bits;
      logic [2:0] colorer_slot;
      logic [31:0] out_x;
      logic [31:0] out_y;
      logic [31:0] out_depth;
      logic [31:0] out_color;
      logic [31:0] out_u;
      logic [31:0] out_v;
      logic [2:0] reuse_mark;
      logic last;
   } rsp_type;

   // emit job handed from the sequencer to the emitter
   typedef struct packed {
      logic start;
      logic [1:0] kind;
      logic [1:0] cull;
      logic [2:0] colorer;
      logic [3:0] count;
   } emit_type;
endpackage

### sv/pa_if.sv
// valid/ready channel interfaces
interface pa_req_if;
   import pa_pkg::*;
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface pa_rsp_if;
   import pa_pkg::*;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### sv/pa_ram.sv
// generic ram, one write port, registered read
module pa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### sv/primitive_assembler_core.sv
// primitive assembler top level: sequencer, slot store and vertex emitter
//
// channel  dir  handshake        payload
// req      in   valid/ready      opcode, draw_mode, vertex attributes
// rsp      out  valid/ready      one emitted vertex per item
// csr      in   csr_write        index, 1 bit data
//
// an item that completes a primitive of n vertices does one slot ram read per vertex
// plus the handoff to the output register
// a polygon split then copies the last slot into slot 1 (ST_COPY_RD, then ST_COPY_WR)
// ready is low while a primitive is read out or a slot is copied; rsp stalls hold the read-out
// reset is synchronous, clears mode, slot, phase, marks and the control registers, and sets both render switches
module primitive_assembler_core
   import pa_pkg::*;
(
   input  logic clock,
   input  logic reset,
   pa_req_if.sink req,
   pa_rsp_if.source rsp,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [0:0] csr_data
);
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT,
      ST_COPY_RD,
      ST_COPY_WR
   } state_type;

   state_type state_ff;
   logic front_cw_ff, render_front_ff, render_back_ff;
   logic [3:0] mode_ff;
   logic [2:0] wslot_ff, phase_ff;
   logic [2:0] mark_ff [SLOTS];
   logic [3:0] idx_ff;
   emit_type job_ff;
   logic copy_after_ff;
   logic [2:0] rslot_ff;
   logic rvalid_ff;
   rsp_type out_ff;
   logic out_valid_ff;

   logic ram_we;
   logic [2:0] ram_wa, ram_ra;
   logic [ATTR_W-1:0] ram_wd, ram_rd;

   pa_ram #(.WIDTH(ATTR_W), .DEPTH(SLOTS)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   logic acc;
   assign req.ready = (state_ff == ST_IDLE);
   assign acc = req.valid && req.ready;

   // facet cull bits from winding and render switches
   function automatic logic [1:0] cull_of(input logic inv, input logic fcw,
                                          input logic rf, input logic rb);
      logic cw, ncw;
      logic [1:0] c;
      cw = ~(fcw ^ inv);
      ncw = ~cw;
      c = 2'd0;
      if (!rf) c = c | (ncw ? 2'd2 : 2'd1);
      if (!rb) c = c | (ncw ? 2'd1 : 2'd2);
      return c;
   endfunction

   // vertex step decisions
   logic [2:0] v, c_ph, nws;
   logic emit;
   logic [1:0] e_kind, e_cull;
   logic [2:0] e_col;
   logic [3:0] e_cnt;
   logic e_inv, is_facet, do_copy, mset0_en, mset1_en;
   logic [2:0] mset0_idx, mset1_idx, mset_val;
   logic [2:0] ph_final;

   always_comb begin
      v = wslot_ff;
      c_ph = (phase_ff >= 3'd7) ? 3'd4 : phase_ff + 3'd1;
      nws = wslot_ff;
      emit = 1'b0;
      is_facet = 1'b0;
      e_kind = KIND_POINT;
      e_inv = 1'b0;
      e_col = 3'd0;
      e_cnt = 4'd0;
      do_copy = 1'b0;
      mset0_en = 1'b0;
      mset1_en = 1'b0;
      mset0_idx = 3'd0;
      mset1_idx = 3'd0;
      mset_val = 3'd0;
      ph_final = c_ph;
      case (mode_ff)
         MODE_POINTS: begin
            emit = 1'b1; e_cnt = 4'd1; nws = 3'd0;
         end
         MODE_LOOP, MODE_STRIP: begin
            if (c_ph > 3'd2) begin
               mset0_en = 1'b1; mset0_idx = (v == 3'd0) ? 3'd1 : 3'd0; mset_val = 3'd1;
            end
            if (c_ph > 3'd1) begin
               emit = 1'b1; e_kind = KIND_LINE; e_cnt = 4'd2;
            end
            nws = (v == 3'd0) ? 3'd1 : 3'd0;
         end
         MODE_LINES: begin
            nws = (v == 3'd0) ? 3'd1 : 3'd0;
            if (v != 3'd0) begin
               emit = 1'b1; e_kind = KIND_LINE; e_cnt = 4'd2;
            end
         end
         MODE_POLYGON: begin
            nws = v + 3'd1;
            if (v == 3'(SLOTS - 1)) begin
               emit = 1'b1; is_facet = 1'b1; e_cnt = 4'(SLOTS);
               do_copy = 1'b1; nws = 3'd2; ph_final = 3'd2;
            end
         end
         MODE_TRISTRIP, MODE_FAN: begin
            nws = v + 3'd1;
            if (c_ph >= 3'd3) begin
               if (c_ph > 3'd3) begin
                  mset0_en = 1'b1; mset1_en = 1'b1; mset_val = 3'd3;
                  mset0_idx = (v == 3'd2) ? 3'd0 : v + 3'd1;
                  mset1_idx = (v == 3'd0) ? 3'd2 : v - 3'd1;
               end
               emit = 1'b1; is_facet = 1'b1; e_cnt = 4'd3;
               e_inv = ~c_ph[0]; e_col = v;
               if (v >= 3'd2) nws = (mode_ff == MODE_TRISTRIP) ? 3'd0 : 3'd1;
            end
         end
         MODE_TRIS: begin
            if (v >= 3'd2) begin
               emit = 1'b1; is_facet = 1'b1; e_cnt = 4'd3; e_col = v; nws = 3'd0;
            end else nws = v + 3'd1;
         end
         MODE_QUADS: begin
            if (v >= 3'd3) begin
               emit = 1'b1; is_facet = 1'b1; e_cnt = 4'd4; e_col = v; nws = 3'd0;
            end else nws = v + 3'd1;
         end
         MODE_QUADSTRIP: begin
            if (c_ph == 3'd1) nws = 3'd1;
            else if (c_ph == 3'd2) nws = 3'd3;
            else if (c_ph == 3'd3) nws = 3'd2;
            else if (c_ph == 3'd4 && mark_ff[1] == 3'd0) begin
               emit = 1'b1; is_facet = 1'b1; e_cnt = 4'd4; e_col = v; nws = 3'd0;
            end else begin
               mset0_en = 1'b1; mset_val = 3'd4;
               mset0_idx = {1'b0, 2'(v[1:0] + 2'd2)};
               if (!c_ph[0]) begin
                  emit = 1'b1; is_facet = 1'b1; e_cnt = 4'd4; e_col = v;
                  e_inv = c_ph[1];
                  nws = {1'b0, 2'(v[1:0] + 2'd2)};
               end else nws = (v == 3'd0) ? 3'd1 : 3'd2;
            end
         end
         default: begin
            nws = wslot_ff;
         end
      endcase
      e_cull = is_facet ? cull_of(e_inv, front_cw_ff, render_front_ff, render_back_ff)
                        : 2'd0;
      if (is_facet) e_kind = KIND_FACET;
      if (is_facet && e_cull == 2'd3) emit = 1'b0;
   end

   logic sub_emit;
   logic [1:0] sub_cull;
   assign sub_cull = cull_of(1'b0, front_cw_ff, render_front_ff, render_back_ff);
   assign sub_emit = (mode_ff == MODE_POLYGON) && (wslot_ff > 3'd2) && (sub_cull != 2'd3);

   logic out_free;
   assign out_free = !out_valid_ff || rsp.ready;

   logic fire;
   assign fire = rvalid_ff && out_free;

   always_comb begin
      ram_we = 1'b0;
      ram_wa = wslot_ff;
      ram_wd = {req.data.vertex_x, req.data.vertex_y, req.data.vertex_depth,
                req.data.vertex_color, req.data.tex_u, req.data.tex_v};
      ram_ra = idx_ff[2:0];
      // a stalled vertex keeps its slot on the read port
      if (rvalid_ff && !fire) ram_ra = rslot_ff;
      if (acc && req.data.opcode == OP_VERTEX) begin
         ram_we = 1'b1;
      end else if (state_ff == ST_COPY_WR) begin
         ram_we = 1'b1; ram_wa = 3'd1; ram_wd = ram_rd;
      end
      if (state_ff == ST_COPY_RD || state_ff == ST_COPY_WR) ram_ra = 3'(SLOTS - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         front_cw_ff <= 1'b0;
         render_front_ff <= 1'b1;
         render_back_ff <= 1'b1;
         mode_ff <= '0;
         wslot_ff <= '0;
         phase_ff <= '0;
         for (int i = 0; i < SLOTS; i++) mark_ff[i] <= '0;
         idx_ff <= '0;
         job_ff <= '0;
         copy_after_ff <= 1'b0;
         rvalid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_FRONT_CW: front_cw_ff <= csr_data[0];
               CSR_RENDER_FRONT: render_front_ff <= csr_data[0];
               CSR_RENDER_BACK: render_back_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (fire) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (acc) begin
                  case (req.data.opcode)
                     OP_BEGIN: begin
                        mode_ff <= req.data.draw_mode;
                        wslot_ff <= '0;
                        phase_ff <= '0;
                     end
                     OP_SUBMIT: begin
                        if (sub_emit) begin
                           job_ff <= '{1'b1, KIND_FACET, sub_cull, 3'd0, {1'b0, wslot_ff}};
                           copy_after_ff <= 1'b0;
                           idx_ff <= '0;
                           state_ff <= ST_READ;
                        end
                     end
                     OP_VERTEX: begin
                        mark_ff[v] <= 3'd0;
                        if (mset0_en) mark_ff[mset0_idx] <= mset_val;
                        if (mset1_en) mark_ff[mset1_idx] <= mset_val;
                        phase_ff <= ph_final;
                        wslot_ff <= nws;
                        copy_after_ff <= do_copy;
                        idx_ff <= '0;
                        job_ff <= '{emit, e_kind, e_cull, e_col, e_cnt};
                        if (emit) state_ff <= ST_READ;
                        else if (do_copy) state_ff <= ST_COPY_RD;
                     end
                     default: ;
                  endcase
               end
            end
            ST_READ: begin
               // ram is read at idx_ff; data lands next cycle
               if (!rvalid_ff || fire) begin
                  rvalid_ff <= 1'b1;
                  rslot_ff <= idx_ff[2:0];
                  idx_ff <= idx_ff + 4'd1;
                  if (idx_ff + 4'd1 == job_ff.count) state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (fire) begin
                  rvalid_ff <= 1'b0;
                  state_ff <= copy_after_ff ? ST_COPY_RD : ST_IDLE;
               end
            end
            ST_COPY_RD: state_ff <= ST_COPY_WR;
            ST_COPY_WR: begin
               mark_ff[1] <= mark_ff[SLOTS - 1];
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // read data is held in the ram register until fire, since ra only moves on fire
   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff.prim_kind <= job_ff.kind;
         out_ff.cull_bits <= job_ff.cull;
         out_ff.colorer_slot <= job_ff.colorer;
         {out_ff.out_x, out_ff.out_y, out_ff.out_depth, out_ff.out_color,
          out_ff.out_u, out_ff.out_v} <= ram_rd;
         out_ff.reuse_mark <= mark_ff[rslot_ff];
         out_ff.last <= ({1'b0, rslot_ff} + 4'd1 == job_ff.count);
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready)
      else $error("ready high while busy");
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> $stable(rsp.data))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_EMIT) |-> job_ff.count != 4'd0)
      else $error("emit with no vertices");
endmodule
